// ===== hw/rtl/ptrd_pkg.sv =====
// Shared types and constants for the pen tablet report decoder.
package ptrd_pkg;

	localparam int REPORT_BYTES   = 10;
	localparam int MIN_REPORT     = 3;
	localparam int PEN_REPORT_MIN = 8;
	localparam int LEN_W          = 4;
	localparam int OUT_DEPTH      = 3;
	localparam int CNT_W          = 2;
	localparam int PTR_W          = 2;
	localparam int IN_TDATA_W     = 16;
	localparam int OUT_TDATA_W    = 112;

	typedef enum logic [2:0] {
		CFG_ACTIVE_MASK = 3'd0,
		CFG_EVENT_MASK  = 3'd1,
		CFG_CONTACT_THR = 3'd2,
		CFG_PEN_CODE    = 3'd3,
		CFG_PROX_CODE   = 3'd4,
		CFG_BUTTON_CODE = 3'd5,
		CFG_ERASER_MASK = 3'd6,
		CFG_STYLUS_MASK = 3'd7
	} cfg_index_t;

	typedef enum logic [1:0] {
		TOOL_UNKNOWN = 2'd0,
		TOOL_STYLUS  = 2'd1,
		TOOL_ERASER  = 2'd2
	} tool_t;

	typedef struct packed {
		logic [3:0]  device_active;
		logic [3:0]  event_enable;
		logic [15:0] contact_threshold;
		logic [7:0]  pen_code;
		logic [7:0]  prox_code;
		logic [7:0]  button_code;
		logic [7:0]  eraser_mask;
		logic [7:0]  stylus_mask;
	} cfg_t;

	// per-device pen state, one memory word
	typedef struct packed {
		logic [15:0] x;
		logic [15:0] y;
		logic [15:0] pressure;
		logic [7:0]  buttons;
		logic [7:0]  tilt_y;
		logic [7:0]  tilt_x;
		tool_t       tool;
		logic        contact;
		logic        prox;
	} pen_state_t;

	typedef struct packed {
		logic [1:0]                    dev;
		logic [LEN_W-1:0]              len;
		logic [REPORT_BYTES-1:0][7:0]  bytes;
		logic [31:0]                   tick;
	} report_t;

	// laid out as the output tdata, lowest field last
	typedef struct packed {
		logic [31:0]       event_time;
		logic              touching;
		logic              near_surface;
		logic [7:0]        button_bits;
		logic [1:0]        tool_kind;
		logic signed [7:0] pen_tilt_y;
		logic signed [7:0] pen_tilt_x;
		logic [15:0]       pen_pressure;
		logic [15:0]       pen_y;
		logic [15:0]       pen_x;
		logic [1:0]        event_device;
	} ev_data_t;

	typedef struct packed {
		logic [7:0] kind;
		ev_data_t   data;
	} event_t;

endpackage

// ===== hw/rtl/pen_tablet_report_decoder_top.sv =====
// Pen tablet report decoder: top level with configuration and stream ports.
// Path: the accepted last report byte loads the stage-one report register, the
//   update stage decodes it and pushes the event into the queue that drives m_axis.
// Throughput: one transaction per cycle; tready drops only while the
//   three-entry event queue plus the item in the state update stage is full.
// Reset (arst_n low, asynchronous): registers to their reset values, tick count,
//   byte count, state valid bits and event queue cleared; no clearing pass.
module pen_tablet_report_decoder_top #(
	parameter int DEVICES = 4
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	// [1:0] device, [9:2] data_byte, [15:10] zero
	input  logic [ptrd_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
	input  logic                                s_axis_tlast,  // last_byte
	input  logic [0:0]                          s_axis_tuser,  // [0] action
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// [1:0] event_device, [17:2] pen_x, [33:18] pen_y, [49:34] pen_pressure,
	// [57:50] pen_tilt_x, [65:58] pen_tilt_y, [67:66] tool_kind,
	// [75:68] button_bits, [76] near_surface, [77] touching,
	// [109:78] event_time, [111:110] zero
	output logic [ptrd_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
	output logic [7:0]                          m_axis_tuser,  // event_kind
	input  logic                                cfg_wr_en,
	input  logic [2:0]                          cfg_index,
	input  logic [15:0]                         cfg_data
);
	import ptrd_pkg::*;

	cfg_t             cfg_q;
	logic             in_fire;
	logic             rep_valid_s1;
	report_t          rep_s1;
	pen_state_t       old_state;
	logic             wr_en;
	logic [1:0]       wr_dev;
	pen_state_t       wr_data;
	logic             ev_push;
	event_t           ev;
	event_t           ev_head;
	logic             pop;
	logic [CNT_W-1:0] fifo_count;

	// Configuration registers; the user must write them only while the block is idle, which the block does not enforce.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.device_active     <= '0;
			cfg_q.event_enable      <= '0;
			cfg_q.contact_threshold <= '0;
			cfg_q.pen_code          <= 8'd1;
			cfg_q.prox_code         <= 8'd2;
			cfg_q.button_code       <= 8'd3;
			cfg_q.eraser_mask       <= '0;
			cfg_q.stylus_mask       <= '0;
		end else if (cfg_wr_en) begin
			case (cfg_index_t'(cfg_index))
				CFG_ACTIVE_MASK: cfg_q.device_active     <= cfg_data[3:0];
				CFG_EVENT_MASK:  cfg_q.event_enable      <= cfg_data[3:0];
				CFG_CONTACT_THR: cfg_q.contact_threshold <= cfg_data;
				CFG_PEN_CODE:    cfg_q.pen_code          <= cfg_data[7:0];
				CFG_PROX_CODE:   cfg_q.prox_code         <= cfg_data[7:0];
				CFG_BUTTON_CODE: cfg_q.button_code       <= cfg_data[7:0];
				CFG_ERASER_MASK: cfg_q.eraser_mask       <= cfg_data[7:0];
				CFG_STYLUS_MASK: cfg_q.stylus_mask       <= cfg_data[7:0];
				default:         cfg_q                   <= cfg_q;
			endcase
		end
	end

	// Credit check: queue entries plus the stage-one item must leave a free
	// slot for whatever we accept now. Registers only, no path from m_axis_tready.
	assign s_axis_tready = ((CNT_W + 1)'(fifo_count) + (CNT_W + 1)'(rep_valid_s1))
	                       < (CNT_W + 1)'(OUT_DEPTH);
	assign in_fire = s_axis_tvalid && s_axis_tready;

	// Stage 0: byte buffer, tick count; state read issued with the incoming device.
	ptrd_assembler u_asm (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_fire      (in_fire),
		.in_tick      (s_axis_tuser[0]),
		.in_dev       (s_axis_tdata[1:0]),
		.in_byte      (s_axis_tdata[9:2]),
		.in_last      (s_axis_tlast),
		.rep_valid_s1 (rep_valid_s1),
		.rep_s1       (rep_s1)
	);

	// Read data lands in stage 1; a write to the same device one transaction
	// earlier is forwarded.
	ptrd_state_ram #(
		.DEVICES (DEVICES)
	) u_ram (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_dev  (s_axis_tdata[1:0]),
		.wr_en   (wr_en),
		.wr_dev  (wr_dev),
		.wr_data (wr_data),
		.rd_data (old_state)
	);

	// Stage 1: decode, merge with stored state, write back, raise an event.
	ptrd_update #(
		.DEVICES (DEVICES)
	) u_upd (
		.rep_valid_s1 (rep_valid_s1),
		.rep_s1       (rep_s1),
		.cfg          (cfg_q),
		.old_state    (old_state),
		.wr_en        (wr_en),
		.wr_dev       (wr_dev),
		.wr_data      (wr_data),
		.ev_push      (ev_push),
		.ev           (ev)
	);

	assign pop = m_axis_tvalid && m_axis_tready;

	ptrd_out_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (ev_push),
		.din       (ev),
		.pop       (pop),
		.not_empty (m_axis_tvalid),
		.dout      (ev_head),
		.count     (fifo_count)
	);

	assign m_axis_tdata = {(OUT_TDATA_W - $bits(ev_data_t))'(0), ev_head.data};
	assign m_axis_tuser = ev_head.kind;

	// An accepted last report byte always reaches the update stage next cycle.
	a_last_reaches_s1: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && !s_axis_tuser[0] && s_axis_tlast |=> rep_valid_s1)
		else $error("last byte did not reach update stage");

	// State is only written for an active device with a live report.
	a_write_active: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> rep_valid_s1 && cfg_q.device_active[rep_s1.dev])
		else $error("state write for inactive device");

	// Events only for devices with events enabled.
	a_event_enabled: assert property (@(posedge clk) disable iff (!arst_n)
		ev_push |-> cfg_q.event_enable[rep_s1.dev])
		else $error("event from disabled device");

	// The credit scheme must keep the event queue from overflowing.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		ev_push |-> (fifo_count != CNT_W'(OUT_DEPTH)) || pop)
		else $error("event queue overflow");

endmodule

// ===== hw/rtl/ptrd_assembler.sv =====
// Report byte assembly, tick counter and the stage-one report register.
module ptrd_assembler (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_fire,
	input  logic              in_tick,
	input  logic [1:0]        in_dev,
	input  logic [7:0]        in_byte,
	input  logic              in_last,
	output logic              rep_valid_s1,
	output ptrd_pkg::report_t rep_s1
);
	import ptrd_pkg::*;

	logic [7:0]                   rbuf_q [REPORT_BYTES];
	logic [LEN_W-1:0]             bytes_seen_q;
	logic [31:0]                  tick_q;
	logic                         room;
	logic                         byte_fire;
	logic                         rep_fire;
	logic [LEN_W-1:0]             len_next;
	logic [REPORT_BYTES-1:0][7:0] merged;

	assign room      = bytes_seen_q < LEN_W'(REPORT_BYTES);
	assign byte_fire = in_fire && !in_tick;
	assign rep_fire  = byte_fire && in_last;
	assign len_next  = room ? bytes_seen_q + LEN_W'(1) : bytes_seen_q;

	// buffer as it stands once the current byte is in
	always_comb begin
		for (int i = 0; i < REPORT_BYTES; i++) begin
			merged[i] = (room && bytes_seen_q == LEN_W'(i)) ? in_byte : rbuf_q[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bytes_seen_q <= '0;
			tick_q       <= '0;
			rep_valid_s1 <= 1'b0;
		end else begin
			rep_valid_s1 <= rep_fire;
			if (in_fire && in_tick) begin
				tick_q <= tick_q + 32'd1;
			end
			if (byte_fire) begin
				bytes_seen_q <= in_last ? '0 : len_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (byte_fire && room) begin
			rbuf_q[bytes_seen_q] <= in_byte;
		end
		if (rep_fire) begin
			rep_s1.dev   <= in_dev;
			rep_s1.len   <= len_next;
			rep_s1.bytes <= merged;
			rep_s1.tick  <= tick_q;
		end
	end

endmodule

// ===== hw/rtl/ptrd_state_ram.sv =====
// Per-device pen state memory with valid bits and write-to-read forwarding.
module ptrd_state_ram #(
	parameter int DEVICES = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [1:0]           rd_dev,
	input  logic                 wr_en,
	input  logic [1:0]           wr_dev,
	input  ptrd_pkg::pen_state_t wr_data,
	output ptrd_pkg::pen_state_t rd_data
);
	import ptrd_pkg::*;

	localparam int AW = (DEVICES > 1) ? $clog2(DEVICES) : 1;

	pen_state_t         mem_q [DEVICES];
	pen_state_t         rd_q;
	pen_state_t         fwd_data_q;
	logic [DEVICES-1:0] valid_q;
	logic               rd_valid_q;
	logic               fwd_q;
	logic [AW-1:0]      rd_addr;
	logic [AW-1:0]      wr_addr;
	logic               rd_in_range;

	assign rd_addr     = AW'(rd_dev);
	assign wr_addr     = AW'(wr_dev);
	assign rd_in_range = 32'(rd_dev) < DEVICES;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_q       <= mem_q[rd_addr];
		fwd_data_q <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
			fwd_q      <= 1'b0;
		end else begin
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			rd_valid_q <= rd_in_range && valid_q[rd_addr];
			fwd_q      <= wr_en && (wr_dev == rd_dev);
		end
	end

	// never-written entries read as the reset state
	assign rd_data = fwd_q ? fwd_data_q : (rd_valid_q ? rd_q : '0);

endmodule

// ===== hw/rtl/ptrd_update.sv =====
// Report decode, pen state update and change detection.
module ptrd_update #(
	parameter int DEVICES = 4
) (
	input  logic                 rep_valid_s1,
	input  ptrd_pkg::report_t    rep_s1,
	input  ptrd_pkg::cfg_t       cfg,
	input  ptrd_pkg::pen_state_t old_state,
	output logic                 wr_en,
	output logic [1:0]           wr_dev,
	output ptrd_pkg::pen_state_t wr_data,
	output logic                 ev_push,
	output ptrd_pkg::event_t     ev
);
	import ptrd_pkg::*;

	logic       is_pen;
	logic       is_prox;
	logic       is_button;
	logic       len_ok;
	logic       dev_ok;
	logic       changed;
	logic [7:0] b [REPORT_BYTES];
	pen_state_t nxt;
	pen_state_t cmp;

	always_comb begin
		for (int i = 0; i < REPORT_BYTES; i++) begin
			b[i] = rep_s1.bytes[i];
		end
	end

	// pen code wins over proximity, proximity over button
	assign is_pen    = b[0] == cfg.pen_code;
	assign is_prox   = !is_pen && b[0] == cfg.prox_code;
	assign is_button = !is_pen && !is_prox && b[0] == cfg.button_code;
	assign dev_ok    = (32'(rep_s1.dev) < DEVICES) && cfg.device_active[rep_s1.dev];
	assign len_ok    = is_pen ? rep_s1.len >= LEN_W'(PEN_REPORT_MIN)
	                          : rep_s1.len >= LEN_W'(MIN_REPORT);

	always_comb begin
		nxt = old_state;
		if (is_pen) begin
			nxt.x        = {b[2], b[1]};
			nxt.y        = {b[4], b[3]};
			nxt.pressure = {b[6], b[5]};
			nxt.buttons  = b[7];
			nxt.prox     = ({b[6], b[5]} != 16'd0) || (b[7] != 8'd0);
			nxt.contact  = {b[6], b[5]} > cfg.contact_threshold;
			if (rep_s1.len >= LEN_W'(REPORT_BYTES)) begin
				nxt.tilt_x = b[8];
				nxt.tilt_y = b[9];
			end
			if ((b[7] & cfg.eraser_mask) != 8'd0) begin
				nxt.tool = TOOL_ERASER;
			end else if ((b[7] & cfg.stylus_mask) != 8'd0) begin
				nxt.tool = TOOL_STYLUS;
			end
		end else if (is_prox) begin
			nxt.prox     = b[1] != 8'd0;
			nxt.contact  = 1'b0;
			nxt.pressure = 16'd0;
		end else if (is_button) begin
			nxt.buttons = b[1];
		end
	end

	// tool change alone is not an event
	always_comb begin
		cmp      = nxt;
		cmp.tool = old_state.tool;
	end
	assign changed = cmp != old_state;

	assign wr_en   = rep_valid_s1 && dev_ok && len_ok && (is_pen || is_prox || is_button);
	assign wr_dev  = rep_s1.dev;
	assign wr_data = nxt;
	assign ev_push = wr_en && changed && cfg.event_enable[rep_s1.dev];

	always_comb begin
		ev.kind              = b[0];
		ev.data.event_time   = rep_s1.tick;
		ev.data.touching     = nxt.contact;
		ev.data.near_surface = nxt.prox;
		ev.data.button_bits  = nxt.buttons;
		ev.data.tool_kind    = nxt.tool;
		ev.data.pen_tilt_y   = $signed(nxt.tilt_y);
		ev.data.pen_tilt_x   = $signed(nxt.tilt_x);
		ev.data.pen_pressure = nxt.pressure;
		ev.data.pen_y        = nxt.y;
		ev.data.pen_x        = nxt.x;
		ev.data.event_device = rep_s1.dev;
	end

endmodule

// ===== hw/rtl/ptrd_out_fifo.sv =====
// Small event queue in front of the output stream.
module ptrd_out_fifo (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  ptrd_pkg::event_t       din,
	input  logic                   pop,
	output logic                   not_empty,
	output ptrd_pkg::event_t       dout,
	output logic [ptrd_pkg::CNT_W-1:0] count
);
	import ptrd_pkg::*;

	event_t           fifo_q [OUT_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(OUT_DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + CNT_W'(1);
				2'b01:   count_q <= count_q - CNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	assign not_empty = count_q != '0;
	assign dout      = fifo_q[rd_ptr_q];
	assign count     = count_q;

endmodule
